// ===== hw/rtl/lazy_cleared_accumulator_table_defines.svh =====
// Assertion macros shared by the lazy cleared accumulator table modules.
`ifndef LAZY_CLEARED_ACCUMULATOR_TABLE_DEFINES_SVH
`define LAZY_CLEARED_ACCUMULATOR_TABLE_DEFINES_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define LCAT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcat assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define LCAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcat assertion failed");
`else
`define LCAT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LCAT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/lcat_pkg.sv =====
// Types and constants shared by the lazy cleared accumulator table modules.
`default_nettype none

package lcat_pkg;

   localparam int DOC_W = 16;
   localparam int CNT_W = 16;

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_TOUCH = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLEAR,
      OP_TOUCH,
      OP_TOUCH_NEW,
      OP_READ
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RMW,
      ST_SWEEP,
      ST_FIRST
   } state_type;

   typedef struct packed {
      logic latch;
      logic step;
      logic finish;
      logic first;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   sweep_last;
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lazy_cleared_accumulator_table.sv =====
// A request is latched in the IDLE state, completed in RMW (a first touch: SWEEP, then
// FIRST) and strobed from the result register; a new one can be taken in the strobe cycle.
// In SWEEP a first touch of an unflagged row sweeps zeros over the row's 2^ROW_BITS
// entries through the single memory port, one per cycle; FIRST then writes a count of one.
// Reset is synchronous: it drops all row flags and the result strobe at once;
// the accumulator memory is not cleared. Results cannot be stalled.
`default_nettype none

module lazy_cleared_accumulator_table
   import lcat_pkg::*;
#(
   parameter int DOC_COUNT = 65536,
   parameter int ROW_BITS  = 10,
   parameter int ROW_COUNT = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [1:0]       req_kind,
   input  wire logic [DOC_W-1:0] req_doc_index,
   output logic                  rsp_valid,
   output logic [CNT_W-1:0]      rsp_count,
   output logic                  rsp_fresh_row
);

   cmd_type    cmd;
   status_type status;

   lcat_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   lcat_dpath #(
      .DOC_COUNT (DOC_COUNT),
      .ROW_BITS  (ROW_BITS),
      .ROW_COUNT (ROW_COUNT)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_kind      (req_kind),
      .req_doc_index (req_doc_index),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_count     (rsp_count),
      .rsp_fresh_row (rsp_fresh_row)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/lcat_ram.sv =====
// Generic single-port RAM with a registered read.
`default_nettype none

module lcat_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                                     clock,
   input  wire logic                                     we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                         wdata,
   output logic      [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lcat_ctrl.sv =====
// Controller state machine for the lazy cleared accumulator table.
`default_nettype none

`include "lazy_cleared_accumulator_table_defines.svh"

module lcat_ctrl
   import lcat_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type status,
   output logic            busy,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (status.op == OP_TOUCH_NEW) ? ST_SWEEP : ST_RMW;
            end
         end
         ST_RMW: begin
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            if (status.sweep_last) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            cmd.latch = start;
         end
         ST_RMW: begin
            cmd.finish = 1'b1;
         end
         ST_SWEEP: begin
            cmd.step = 1'b1;
         end
         ST_FIRST: begin
            cmd.first = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   `LCAT_ASSERT_NEXT(a_sweep_exit, clock, reset, state_ff == ST_SWEEP && status.sweep_last, state_ff == ST_FIRST)
   `LCAT_ASSERT_NEXT(a_one_result, clock, reset, state_ff == ST_RMW || state_ff == ST_FIRST, state_ff == ST_IDLE)

endmodule

`default_nettype wire

// ===== hw/rtl/lcat_dpath.sv =====
// Datapath: row flags, accumulator memory, sweep counter and result register.
`default_nettype none

`include "lazy_cleared_accumulator_table_defines.svh"

module lcat_dpath
   import lcat_pkg::*;
#(
   parameter int DOC_COUNT = 65536,
   parameter int ROW_BITS  = 10,
   parameter int ROW_COUNT = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   input  wire logic [1:0]       req_kind,
   input  wire logic [DOC_W-1:0] req_doc_index,
   output status_type            status,
   output logic                  rsp_valid,
   output logic [CNT_W-1:0]      rsp_count,
   output logic                  rsp_fresh_row
);

   localparam int MEM_DEPTH  = (DOC_COUNT < (1 << DOC_W)) ? DOC_COUNT : (1 << DOC_W);
   localparam int ADDR_W     = $clog2(MEM_DEPTH);
   localparam int ROW_SPAN   = 1 << (DOC_W - ROW_BITS);
   localparam int FLAG_COUNT = (ROW_COUNT < ROW_SPAN) ? ROW_COUNT : ROW_SPAN;
   localparam int FLAG_W     = (FLAG_COUNT > 1) ? $clog2(FLAG_COUNT) : 1;
   localparam int FLAG_SLOTS = 1 << FLAG_W;
   localparam logic [DOC_W-1:0] LOW_MASK = DOC_W'((64'd1 << ROW_BITS) - 64'd1);

   logic [FLAG_SLOTS-1:0] flags_ff;
   logic [FLAG_SLOTS-1:0] flags_in;
   op_type                op_ff;
   logic [DOC_W-1:0]      doc_ff;
   logic [FLAG_W-1:0]     slot_ff;
   logic [ROW_BITS-1:0]   sweep_cnt_ff;
   logic                  rsp_valid_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic                  rsp_fresh_ff;

   logic [DOC_W:0]        req_row;
   logic [FLAG_W-1:0]     req_slot;
   logic                  req_ok;
   logic                  req_flag;
   op_type                req_op;
   logic [DOC_W-1:0]      sweep_addr;
   logic                  sweep_in_table;
   logic                  ram_we;
   logic [DOC_W-1:0]      ram_addr_full;
   logic [CNT_W-1:0]      ram_wdata;
   logic [CNT_W-1:0]      ram_rdata;
   logic [CNT_W-1:0]      bumped;

   // Decode of the request that is offered on the inputs.
   always_comb begin
      req_row  = {1'b0, req_doc_index} >> ROW_BITS;
      req_slot = req_row[FLAG_W-1:0];
      req_ok   = (32'(req_doc_index) < 32'(DOC_COUNT)) && (32'(req_row) < 32'(ROW_COUNT));
      req_flag = req_ok && flags_ff[req_slot];
      case (req_kind)
         KIND_CLEAR: req_op = OP_CLEAR;
         KIND_TOUCH: begin
            if (!req_ok) begin
               req_op = OP_NONE;
            end else begin
               req_op = req_flag ? OP_TOUCH : OP_TOUCH_NEW;
            end
         end
         KIND_READ:  req_op = req_flag ? OP_READ : OP_NONE;
         default:    req_op = OP_NONE;
      endcase
   end

   always_comb begin
      flags_in = flags_ff;
      if (cmd.latch) begin
         if (req_op == OP_CLEAR) begin
            flags_in = '0;
         end else if (req_op == OP_TOUCH_NEW) begin
            flags_in[req_slot] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         flags_ff     <= flags_in;
         rsp_valid_ff <= cmd.finish || cmd.first;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff        <= req_op;
         doc_ff       <= req_doc_index;
         slot_ff      <= req_slot;
         sweep_cnt_ff <= '0;
      end else if (cmd.step) begin
         sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
      end
      if (cmd.first) begin
         rsp_count_ff <= CNT_W'(1);
         rsp_fresh_ff <= 1'b1;
      end else if (cmd.finish) begin
         rsp_fresh_ff <= 1'b0;
         case (op_ff)
            OP_TOUCH: rsp_count_ff <= bumped;
            OP_READ:  rsp_count_ff <= ram_rdata;
            default:  rsp_count_ff <= '0;
         endcase
      end
   end

   // The sweep walks the row of the latched document; entries past the table end are skipped.
   always_comb begin
      sweep_addr     = (doc_ff & ~LOW_MASK) | DOC_W'(sweep_cnt_ff);
      sweep_in_table = 32'(sweep_addr) < 32'(DOC_COUNT);
      bumped         = ram_rdata + 1'b1;
      if (cmd.step) begin
         ram_addr_full = sweep_addr;
      end else if (cmd.finish || cmd.first) begin
         ram_addr_full = doc_ff;
      end else begin
         ram_addr_full = req_doc_index;
      end
      ram_we    = (cmd.step && sweep_in_table) || cmd.first ||
                  (cmd.finish && op_ff == OP_TOUCH);
      if (cmd.step) begin
         ram_wdata = '0;
      end else if (cmd.first) begin
         ram_wdata = CNT_W'(1);
      end else begin
         ram_wdata = bumped;
      end
   end

   lcat_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MEM_DEPTH)
   ) u_acc_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr_full[ADDR_W-1:0]),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign status.op         = req_op;
   assign status.sweep_last = &sweep_cnt_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_fresh_row     = rsp_fresh_ff;

   `LCAT_ASSERT_IMPLY(a_fresh_is_one, clock, reset, rsp_valid_ff && rsp_fresh_ff, rsp_count_ff == CNT_W'(1))
   `LCAT_ASSERT_IMPLY(a_first_flagged, clock, reset, cmd.first, flags_ff[slot_ff])
   `LCAT_ASSERT_NEXT(a_strobe_follows, clock, reset, cmd.finish || cmd.first, rsp_valid_ff)

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the lazily cleared accumulator table, with its own prediction.
`default_nettype none

module tb_top;
   import lcat_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DOC_COUNT = 65536;
   localparam int ROW_BITS  = 10;
   localparam int ROW_COUNT = 64;
   localparam int ROW_LEN   = 1 << ROW_BITS;
   localparam int RANDOM_REQUESTS = 1450;
   localparam int SETTLE_CYCLES   = 50;
   localparam int REPORT_LIMIT    = 10;

   // The package names only the kinds the block acts on.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]       kind;
      logic [DOC_W-1:0] doc;
      bit               drain;
   } request_type;

   typedef struct {
      logic [CNT_W-1:0] count;
      logic             fresh;
   } result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [1:0]       req_kind = KIND_CLEAR;
   logic [DOC_W-1:0] req_doc_index = '0;
   logic             rsp_valid;
   logic [CNT_W-1:0] rsp_count;
   logic             rsp_fresh_row;

   request_type request_q[$];
   result_type  expected_q[$];

   logic [CNT_W-1:0] acc_mem [DOC_COUNT];
   bit               row_flag [ROW_COUNT];

   bit taken = 1'b0;
   int burst_left = 10;
   int gap_left = 0;
   int failures = 0;

   lazy_cleared_accumulator_table #(
      .DOC_COUNT(DOC_COUNT),
      .ROW_BITS (ROW_BITS),
      .ROW_COUNT(ROW_COUNT)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_doc_index(req_doc_index),
      .rsp_valid    (rsp_valid),
      .rsp_count    (rsp_count),
      .rsp_fresh_row(rsp_fresh_row)
   );

   always #5 clock = ~clock;

   task automatic add_request(input logic [1:0] kind, input logic [DOC_W-1:0] doc,
                              input bit drain);
      request_type req;
      req.kind = kind;
      req.doc = doc;
      req.drain = drain;
      request_q.push_back(req);
   endtask

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endtask

   // Applies one request to the shadow table and returns the result it should give.
   task automatic table_predict(input logic [1:0] kind, input logic [DOC_W-1:0] doc,
                                output result_type res);
      int unsigned d;
      int unsigned row;
      int unsigned first;
      bit          in_range;
      d = 32'(doc);
      row = d >> ROW_BITS;
      in_range = (d < DOC_COUNT) && (row < ROW_COUNT);
      res.count = '0;
      res.fresh = 1'b0;
      case (kind)
         KIND_CLEAR: begin
            foreach (row_flag[i]) row_flag[i] = 1'b0;
         end
         KIND_TOUCH: begin
            if (in_range) begin
               if (!row_flag[row]) begin
                  row_flag[row] = 1'b1;
                  first = row << ROW_BITS;
                  for (int unsigned i = first; i < first + ROW_LEN && i < DOC_COUNT; i++) begin
                     acc_mem[i] = '0;
                  end
                  res.fresh = 1'b1;
               end
               acc_mem[d] = acc_mem[d] + 1'b1;
               res.count = acc_mem[d];
            end
         end
         KIND_READ: begin
            if (in_range && row_flag[row]) begin
               res.count = acc_mem[d];
            end
         end
         default: ;
      endcase
   endtask

   // Driver: a request stays on the ports until it is taken; bursts alternate with gaps.
   always @(negedge clock) begin
      request_type nxt;
      bit          go;
      go = 1'b0;
      if (!reset && !(start && !taken)) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (request_q.size() > 0 &&
                      (!request_q[0].drain || expected_q.size() == 0)) begin
            go = 1'b1;
         end
         if (go) begin
            nxt = request_q.pop_front();
            req_kind <= nxt.kind;
            req_doc_index <= nxt.doc;
            start <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks each strobed result, then records a request taken at this edge.
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         taken = 1'b0;
      end else begin
         if (rsp_valid) begin
            got.count = rsp_count;
            got.fresh = rsp_fresh_row;
            if (expected_q.size() == 0) begin
               note_failure($sformatf("result with none pending: count %0d fresh_row %0b",
                                      got.count, got.fresh));
            end else begin
               want = expected_q.pop_front();
               if (got.count !== want.count) begin
                  note_failure($sformatf("count: expected %0d, got %0d",
                                         want.count, got.count));
               end
               if (got.fresh !== want.fresh) begin
                  note_failure($sformatf("fresh_row: expected %0b, got %0b",
                                         want.fresh, got.fresh));
               end
            end
         end
         taken = start && !busy;
         if (taken) begin
            table_predict(req_kind, req_doc_index, want);
            expected_q.push_back(want);
         end
      end
   end

   initial begin
      int unsigned rows [3];
      int          n_rows;
      int          ep_len;
      int          pick;
      int unsigned row;
      int unsigned offset;
      int          issued;
      bit          drained_mid;
      bit          drain;
      logic [1:0]  kind;

      foreach (row_flag[i]) row_flag[i] = 1'b0;

      // Directed part: row flag behavior, both ends of the index, clear and unused kind.
      add_request(KIND_READ,   16'h0000, 1'b0);
      add_request(KIND_TOUCH,  16'h0000, 1'b0);
      add_request(KIND_TOUCH,  16'h0000, 1'b0);
      add_request(KIND_TOUCH,  16'h03FF, 1'b0);
      add_request(KIND_READ,   16'h0000, 1'b0);
      add_request(KIND_READ,   16'h03FF, 1'b0);
      add_request(KIND_READ,   16'h0400, 1'b0);
      add_request(KIND_TOUCH,  16'hFFFF, 1'b0);
      add_request(KIND_TOUCH,  16'hFC00, 1'b0);
      add_request(KIND_READ,   16'hFFFF, 1'b0);
      add_request(KIND_UNUSED, 16'hFFFF, 1'b0);
      add_request(KIND_UNUSED, 16'h0000, 1'b0);
      add_request(KIND_CLEAR,  16'hAAAA, 1'b0);
      add_request(KIND_READ,   16'h0000, 1'b0);
      add_request(KIND_READ,   16'hFFFF, 1'b0);
      // After a clear the first touch must sweep the stale values out of the row.
      add_request(KIND_TOUCH,  16'h0000, 1'b0);
      add_request(KIND_READ,   16'h03FF, 1'b0);
      add_request(KIND_TOUCH,  16'h5555, 1'b1);
      add_request(KIND_READ,   16'h5555, 1'b0);
      add_request(KIND_TOUCH,  16'hAAAA, 1'b0);
      add_request(KIND_CLEAR,  16'h5555, 1'b0);
      add_request(KIND_TOUCH,  16'hAAAA, 1'b0);

      // Random part: episodes that work on a few rows so that counts build up.
      issued = 0;
      drained_mid = 1'b0;
      while (issued < RANDOM_REQUESTS) begin
         n_rows = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(1, 2);
         for (int i = 0; i < n_rows; i++) rows[i] = $urandom_range(0, ROW_COUNT - 1);
         ep_len = $urandom_range(20, 80);
         drain = 1'b0;
         if (!drained_mid && issued > RANDOM_REQUESTS / 2) begin
            drain = 1'b1;
            drained_mid = 1'b1;
         end
         if ($urandom_range(0, 2) == 0) begin
            add_request(KIND_CLEAR, DOC_W'($urandom), drain);
            drain = 1'b0;
            issued++;
         end
         for (int j = 0; j < ep_len; j++) begin
            pick = $urandom_range(0, 99);
            row = rows[$urandom_range(0, n_rows - 1)];
            if ($urandom_range(0, 19) == 0) row = $urandom_range(0, ROW_COUNT - 1);
            offset = $urandom_range(0, 1) ? $urandom_range(0, 7)
                                           : $urandom_range(0, ROW_LEN - 1);
            if (pick < 2) kind = KIND_CLEAR;
            else if (pick < 4) kind = KIND_UNUSED;
            else if (pick < 60) kind = KIND_TOUCH;
            else kind = KIND_READ;
            add_request(kind, DOC_W'((row << ROW_BITS) | offset), drain);
            drain = 1'b0;
            if (kind != KIND_UNUSED) issued++;
         end
      end

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (request_q.size() != 0 || start || expected_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (failures == 0 && expected_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lcat_pkg.sv
hw/rtl/lcat_ram.sv
hw/rtl/lcat_ctrl.sv
hw/rtl/lcat_dpath.sv
hw/rtl/lazy_cleared_accumulator_table.sv
verif/tb_top.sv
